// ===== src/lpp_pkg.sv =====
// Shared types, constants and helpers for the lidar point project filter.
package lpp_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int SENSOR_Z_OFFSET_MM = 0;
  localparam int MOUNT_HEIGHT_MM = 1320;

  localparam logic signed [32:0] CORDIC_X_INIT = 33'sd652032875;
  localparam logic signed [31:0] ZOFF_Q15 = 32'(SENSOR_Z_OFFSET_MM * 32768);
  localparam logic signed [21:0] MOUNT_H = 22'(MOUNT_HEIGHT_MM);

  localparam logic [10:0] BEAM_WIN_LO = 11'd400;
  localparam logic [10:0] BEAM_WIN_HI = 11'd680;

  typedef logic signed [31:0] atan_tab_t [CORDIC_STEPS];
  localparam atan_tab_t ATAN_TAB = '{
    32'sd294912000, 32'sd174096719, 32'sd91987925, 32'sd46694507,
    32'sd23437865, 32'sd11730358, 32'sd5866610, 32'sd2933485,
    32'sd1466765, 32'sd733385, 32'sd366693, 32'sd183347,
    32'sd91674, 32'sd45837, 32'sd22919, 32'sd11459
  };

  typedef enum logic [3:0] {
    REG_INT_MIN = 4'd0,
    REG_INT_MAX = 4'd1,
    REG_X_MIN   = 4'd2,
    REG_X_MAX   = 4'd3,
    REG_Y_MIN   = 4'd4,
    REG_Y_MAX   = 4'd5,
    REG_Z_MIN   = 4'd6,
    REG_Z_MAX   = 4'd7
  } reg_idx_t;

  typedef struct packed {
    logic        neg;
    logic [15:0] range_mm;
    logic [15:0] inten;
  } side_t;

  // half-up round of a 2^-30 CORDIC value to Q1.15, saturated
  function automatic logic signed [15:0] rnd_q15(input logic signed [32:0] v,
                                                 input logic neg);
    logic signed [33:0] t;
    logic signed [18:0] s;
    t = neg ? -34'(v) : 34'(v);
    t = t + 34'sd16384;
    s = 19'(t >>> 15);
    if (s > 19'sd32767) return 16'sh7fff;
    else if (s < -19'sd32768) return 16'sh8000;
    else return s[15:0];
  endfunction

  function automatic logic signed [17:0] sat18(input logic signed [23:0] v);
    if (v > 24'sd131071) return 18'sh1ffff;
    else if (v < -24'sd131072) return 18'sh20000;
    else return v[17:0];
  endfunction

endpackage

// ===== src/lpp_ifs.sv =====
// Channel interfaces: input return, output point, configuration write.
interface lpp_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pan_angle;
  logic [10:0]        beam_index;
  logic [15:0]        range_mm;
  logic [15:0]        return_intensity;
  modport source (output valid, pan_angle, beam_index, range_mm, return_intensity,
                  input ready);
  modport sink (input valid, pan_angle, beam_index, range_mm, return_intensity,
                output ready);
endinterface

interface lpp_out_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] point_x;
  logic signed [17:0] point_y;
  logic signed [17:0] point_z;
  logic [15:0]        point_intensity;
  modport source (output valid, point_x, point_y, point_z, point_intensity,
                  input ready);
  modport sink (input valid, point_x, point_y, point_z, point_intensity,
                output ready);
endinterface

interface lpp_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [17:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/lpp_cordic.sv =====
// Pipelined rotation CORDIC, one micro-rotation per register stage.
module lpp_cordic (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] z_in,
  output logic signed [32:0] x_out,
  output logic signed [32:0] y_out
);

  localparam int N = lpp_pkg::CORDIC_STEPS;

  logic signed [32:0] x [N+1];
  logic signed [32:0] y [N+1];
  logic signed [31:0] z [N+1];

  assign x[0] = lpp_pkg::CORDIC_X_INIT;
  assign y[0] = '0;
  assign z[0] = z_in;

  for (genvar i = 0; i < N; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z[i][31]) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - lpp_pkg::ATAN_TAB[i];
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + lpp_pkg::ATAN_TAB[i];
        end
      end
    end
  end

  assign x_out = x[N];
  assign y_out = y[N];

endmodule

// ===== src/lidar_point_project_filter_top.sv =====
// Top level: lidar return projection to Cartesian mm and box/intensity filter.
//
// Channels: in_ch takes one return (pan, beam index, range, intensity) per
// transaction; out_ch gives one kept point per transaction; cfg writes one
// of eight registers (index 0..7, others ignored) and is always ready.
// The path from input transaction to output valid runs through 22
// register stages: angle reduction in front of the first register, 16 CORDIC
// stages (pan and tilt lanes side by side), then rounding, two multiply
// stages, sum/round/saturate, and the filter compare into the output
// register. One return is taken per cycle while out_ch does not stall.
// Returns outside the +-35 degree tilt window, outside the box or outside
// the intensity range leave the pipeline without a transaction.
// Reset (rst, synchronous) clears all valid bits and loads the register
// defaults. When out_ch stalls with a point waiting, the whole pipeline
// holds and in_ch.ready drops; nothing is lost or repeated.
module lidar_point_project_filter_top (
  input logic         clk,
  input logic         rst,
  lpp_in_if.sink      in_ch,
  lpp_out_if.source   out_ch,
  lpp_cfg_if.sink     cfg
);

  localparam int N = lpp_pkg::CORDIC_STEPS;

  // configuration
  logic [15:0]        intensity_min, intensity_max;
  logic signed [17:0] box_x_min, box_x_max, box_y_min, box_y_max;
  logic signed [17:0] box_z_min, box_z_max;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      intensity_min <= 16'd100;
      intensity_max <= 16'd4000;
      box_x_min <= 18'sd0;
      box_x_max <= 18'sd8000;
      box_y_min <= -18'sd4000;
      box_y_max <= 18'sd5000;
      box_z_min <= 18'sd0;
      box_z_max <= 18'sd2500;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        lpp_pkg::REG_INT_MIN: intensity_min <= cfg.data[15:0];
        lpp_pkg::REG_INT_MAX: intensity_max <= cfg.data[15:0];
        lpp_pkg::REG_X_MIN:   box_x_min <= cfg.data;
        lpp_pkg::REG_X_MAX:   box_x_max <= cfg.data;
        lpp_pkg::REG_Y_MIN:   box_y_min <= cfg.data;
        lpp_pkg::REG_Y_MAX:   box_y_max <= cfg.data;
        lpp_pkg::REG_Z_MIN:   box_z_min <= cfg.data;
        lpp_pkg::REG_Z_MAX:   box_z_max <= cfg.data;
        default: ;
      endcase
    end
  end

  // global advance
  logic en;
  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // stage 0: angle reduction, tilt and window check
  logic signed [16:0] pan_w, pan_r;
  logic signed [16:0] pan_f;
  logic               pan_neg;
  logic signed [15:0] tilt;
  logic               in_win;

  always_comb begin
    pan_w = 17'(in_ch.pan_angle);
    if (pan_w >= 17'sd18000) pan_r = pan_w - 17'sd36000;
    else if (pan_w < -17'sd18000) pan_r = pan_w + 17'sd36000;
    else pan_r = pan_w;
    if (pan_r > 17'sd9000) begin
      pan_f = pan_r - 17'sd18000;
      pan_neg = 1'b1;
    end else if (pan_r < -17'sd9000) begin
      pan_f = pan_r + 17'sd18000;
      pan_neg = 1'b1;
    end else begin
      pan_f = pan_r;
      pan_neg = 1'b0;
    end
    tilt = $signed(16'(in_ch.beam_index * 16'd25) - 16'd13500);
    in_win = (in_ch.beam_index >= lpp_pkg::BEAM_WIN_LO) &&
             (in_ch.beam_index <= lpp_pkg::BEAM_WIN_HI);
  end

  logic               v0;
  logic signed [31:0] z_pan, z_tilt;
  lpp_pkg::side_t     sb [N+1];
  logic [N:0]         vs;

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (en) v0 <= in_ch.valid && in_win;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z_pan  <= {pan_f[15:0], 16'h0000};
      z_tilt <= {tilt, 16'h0000};
      sb[0]  <= '{neg: pan_neg, range_mm: in_ch.range_mm,
                  inten: in_ch.return_intensity};
    end
  end

  // CORDIC lanes with sideband line
  logic signed [32:0] xp, yp, xt, yt;

  lpp_cordic u_cordic_pan (.clk, .en, .z_in(z_pan), .x_out(xp), .y_out(yp));
  lpp_cordic u_cordic_tilt (.clk, .en, .z_in(z_tilt), .x_out(xt), .y_out(yt));

  assign vs[0] = v0;

  for (genvar i = 0; i < N; i++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) vs[i+1] <= 1'b0;
      else if (en) vs[i+1] <= vs[i];
    end
    always_ff @(posedge clk) begin
      if (en) sb[i+1] <= sb[i];
    end
  end

  // rounding to Q1.15
  logic               v_r;
  logic signed [15:0] cp, sp, ct, st;
  logic [15:0]        r_r, i_r;

  always_ff @(posedge clk) begin
    if (rst) v_r <= 1'b0;
    else if (en) v_r <= vs[N];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cp  <= lpp_pkg::rnd_q15(xp, sb[N].neg);
      sp  <= lpp_pkg::rnd_q15(yp, sb[N].neg);
      ct  <= lpp_pkg::rnd_q15(xt, 1'b0);
      st  <= lpp_pkg::rnd_q15(yt, 1'b0);
      r_r <= sb[N].range_mm;
      i_r <= sb[N].inten;
    end
  end

  // multiply 1
  logic               v_m1;
  logic signed [32:0] rc, yprod;
  logic signed [47:0] cpzo, spzo;
  logic signed [15:0] cp1, sp1;
  logic [15:0]        i_m1;

  always_ff @(posedge clk) begin
    if (rst) v_m1 <= 1'b0;
    else if (en) v_m1 <= v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rc    <= $signed({1'b0, r_r}) * ct;
      yprod <= $signed({1'b0, r_r}) * st;
      cpzo  <= cp * lpp_pkg::ZOFF_Q15;
      spzo  <= sp * lpp_pkg::ZOFF_Q15;
      cp1   <= cp;
      sp1   <= sp;
      i_m1  <= i_r;
    end
  end

  // multiply 2
  logic               v_m2;
  logic signed [48:0] xa, zb;
  logic signed [47:0] cpzo2, spzo2;
  logic signed [32:0] yprod2;
  logic [15:0]        i_m2;

  always_ff @(posedge clk) begin
    if (rst) v_m2 <= 1'b0;
    else if (en) v_m2 <= v_m1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xa     <= cp1 * rc;
      zb     <= sp1 * rc;
      cpzo2  <= cpzo;
      spzo2  <= spzo;
      yprod2 <= yprod;
      i_m2   <= i_m1;
    end
  end

  // sum, round, saturate
  logic signed [50:0] xs, zs;
  logic signed [33:0] ys;
  logic signed [21:0] zc;
  logic               v_s;
  logic signed [17:0] px, py, pz;
  logic [15:0]        i_s;

  always_comb begin
    xs = 51'(xa) + 51'(spzo2) + 51'sd536870912;
    zs = 51'(cpzo2) - 51'(zb) + 51'sd536870912;
    ys = 34'(yprod2) + 34'sd16384;
    zc = 22'(zs >>> 30) + lpp_pkg::MOUNT_H;
  end

  always_ff @(posedge clk) begin
    if (rst) v_s <= 1'b0;
    else if (en) v_s <= v_m2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px  <= lpp_pkg::sat18(24'(xs >>> 30));
      py  <= lpp_pkg::sat18(24'(ys >>> 15));
      pz  <= lpp_pkg::sat18(24'(zc));
      i_s <= i_m2;
    end
  end

  // filter into output register
  logic keep;
  assign keep = (px >= box_x_min) && (px <= box_x_max) &&
                (py >= box_y_min) && (py <= box_y_max) &&
                (pz >= box_z_min) && (pz <= box_z_max) &&
                (i_s >= intensity_min) && (i_s <= intensity_max);

  always_ff @(posedge clk) begin
    if (rst) out_ch.valid <= 1'b0;
    else if (en) out_ch.valid <= v_s && keep;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ch.point_x         <= px;
      out_ch.point_y         <= py;
      out_ch.point_z         <= pz;
      out_ch.point_intensity <= i_s;
    end
  end

  a_rst_clears: assert property (@(posedge clk) rst |=> !out_ch.valid)
    else $error("output valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vs) && $stable(v_s) && $stable(v_m2))
    else $error("pipeline moved during stall");

  a_int_range: assert property (@(posedge clk) disable iff (rst)
    $past(en) && !$past(rst) && out_ch.valid |->
      out_ch.point_intensity >= $past(intensity_min) &&
      out_ch.point_intensity <= $past(intensity_max))
    else $error("intensity filter leak");

  a_win_drop: assert property (@(posedge clk) disable iff (rst)
    en && in_ch.valid && !in_win |=> !v0)
    else $error("out-of-window beam entered pipeline");

endmodule

// ===== sim/lpp_checker.sv =====
// Checker: watches the point channels, predicts kept points and compares them.
`timescale 1ns / 1ps
module lpp_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [15:0] in_pan,
  input  logic [10:0] in_beam,
  input  logic [15:0] in_range,
  input  logic [15:0] in_inten,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [17:0] out_x,
  input  logic [17:0] out_y,
  input  logic [17:0] out_z,
  input  logic [15:0] out_inten,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [17:0] cfg_data,
  output int          fail_count,
  output int          pending_points
);

  typedef struct packed {
    logic [17:0] x;
    logic [17:0] y;
    logic [17:0] z;
    logic [15:0] inten;
  } point_t;

  localparam longint ATAN_STEP [16] = '{
    294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
    5866610, 2933485, 1466765, 733385, 366693, 183347,
    91674, 45837, 22919, 11459
  };

  point_t      kept_points [$];
  logic [15:0] int_lo, int_hi;
  longint      bx_lo, bx_hi, by_lo, by_hi, bz_lo, bz_hi;

  assign pending_points = kept_points.size();

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic void sin_cos(input longint ang, output longint c, output longint s);
    longint x, y, z, t, dx, dy;
    logic   flip;
    x = 652032875;
    y = 0;
    flip = 0;
    ang = ang % 36000;
    if (ang < 0) ang += 36000;
    if (ang >= 18000) ang -= 36000;
    if (ang > 9000) begin
      ang -= 18000;
      flip = 1;
    end else if (ang < -9000) begin
      ang += 18000;
      flip = 1;
    end
    z = ang * 65536;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        t = x - dx;
        y = y + dy;
        z -= ATAN_STEP[i];
      end else begin
        t = x + dx;
        y = y - dy;
        z += ATAN_STEP[i];
      end
      x = t;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = clamp((x + 16384) >>> 15, -32768, 32767);
    s = clamp((y + 16384) >>> 15, -32768, 32767);
  endfunction

  function automatic logic project_point(input logic [15:0] pan, input logic [10:0] beam,
                                         input logic [15:0] rng, input logic [15:0] inten,
                                         output point_t p);
    longint tilt, ct, st, cp, sp, rc, zo, x, y, z;
    tilt = -13500 + 25 * longint'(beam);
    if (tilt < -3500 || tilt > 3500) return 0;
    sin_cos(tilt, ct, st);
    sin_cos(longint'($signed(pan)), cp, sp);
    zo = longint'(lpp_pkg::SENSOR_Z_OFFSET_MM) * 32768;
    rc = longint'(rng) * ct;
    x = (cp * rc + sp * zo + (64'sd1 <<< 29)) >>> 30;
    y = (longint'(rng) * st + 16384) >>> 15;
    z = ((cp * zo - sp * rc + (64'sd1 <<< 29)) >>> 30) + lpp_pkg::MOUNT_HEIGHT_MM;
    x = clamp(x, -131072, 131071);
    y = clamp(y, -131072, 131071);
    z = clamp(z, -131072, 131071);
    if (x < bx_lo || x > bx_hi || y < by_lo || y > by_hi || z < bz_lo || z > bz_hi)
      return 0;
    if (inten < int_lo || inten > int_hi) return 0;
    p = '{x[17:0], y[17:0], z[17:0], inten};
    return 1;
  endfunction

  always @(posedge clk) begin
    point_t p, got;
    if (rst) begin
      int_lo <= 100;
      int_hi <= 4000;
      bx_lo <= 0;
      bx_hi <= 8000;
      by_lo <= -4000;
      by_hi <= 5000;
      bz_lo <= 0;
      bz_hi <= 2500;
      fail_count <= 0;
      kept_points.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lpp_pkg::REG_INT_MIN: int_lo <= cfg_data[15:0];
          lpp_pkg::REG_INT_MAX: int_hi <= cfg_data[15:0];
          lpp_pkg::REG_X_MIN:   bx_lo <= longint'($signed(cfg_data));
          lpp_pkg::REG_X_MAX:   bx_hi <= longint'($signed(cfg_data));
          lpp_pkg::REG_Y_MIN:   by_lo <= longint'($signed(cfg_data));
          lpp_pkg::REG_Y_MAX:   by_hi <= longint'($signed(cfg_data));
          lpp_pkg::REG_Z_MIN:   bz_lo <= longint'($signed(cfg_data));
          lpp_pkg::REG_Z_MAX:   bz_hi <= longint'($signed(cfg_data));
          default: ;
        endcase
      end
      if (in_valid && in_ready && project_point(in_pan, in_beam, in_range, in_inten, p))
        kept_points = {kept_points, p};
      if (out_valid && out_ready) begin
        got = '{out_x, out_y, out_z, out_inten};
        if (kept_points.size() == 0) begin
          $error("unexpected point transaction x=%0d", $signed(out_x));
          fail_count <= fail_count + 1;
        end else begin
          p = kept_points.pop_front();
          if (got.x !== p.x) $error("point_x exp %0d got %0d", $signed(p.x), $signed(got.x));
          if (got.y !== p.y) $error("point_y exp %0d got %0d", $signed(p.y), $signed(got.y));
          if (got.z !== p.z) $error("point_z exp %0d got %0d", $signed(p.z), $signed(got.z));
          if (got.inten !== p.inten)
            $error("point_intensity exp %0d got %0d", p.inten, got.inten);
          if (got !== p) fail_count <= fail_count + 1;
        end
      end
    end
  end

endmodule

// ===== sim/testbench.sv =====
// Testbench top: stimulus, register phases and verdict for the point filter.
`timescale 1ns / 1ps
module testbench;

  localparam int LATENCY = 22;
  localparam int STALL_LIMIT = 20000;

  logic clk = 0;
  logic rst = 1;
  int   fail_count, pending_points, idle_cycles;
  logic sink_hold = 0;

  lpp_in_if  in_ch();
  lpp_out_if out_ch();
  lpp_cfg_if cfg();

  lidar_point_project_filter_top u_top (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg)
  );

  lpp_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_pan(in_ch.pan_angle),
    .in_beam(in_ch.beam_index), .in_range(in_ch.range_mm),
    .in_inten(in_ch.return_intensity),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_x(out_ch.point_x),
    .out_y(out_ch.point_y), .out_z(out_ch.point_z), .out_inten(out_ch.point_intensity),
    .cfg_valid(cfg.valid), .cfg_ready(cfg.ready), .cfg_index(cfg.index),
    .cfg_data(cfg.data), .fail_count(fail_count), .pending_points(pending_points)
  );

  always #5 clk = ~clk;

  // receiver: random per-transaction stalls, long hold-off on request
  always @(posedge clk) begin
    int gap;
    if (rst) begin
      out_ch.ready <= 0;
    end else if (sink_hold) begin
      out_ch.ready <= 0;
    end else if (out_ch.ready && out_ch.valid) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      if (gap != 0) begin
        out_ch.ready <= 0;
        repeat (gap - 1) @(posedge clk);
        out_ch.ready <= 1;
      end
    end else begin
      out_ch.ready <= 1;
    end
  end

  always @(posedge clk) begin
    if (rst || in_ch.valid && in_ch.ready || out_ch.valid && out_ch.ready || cfg.valid)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_reg(input lpp_pkg::reg_idx_t idx, input logic [17:0] value);
    cfg.valid <= 1;
    cfg.index <= idx;
    cfg.data <= value;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 0;
  endtask

  task automatic drain();
    while (pending_points != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic send_return(input logic [15:0] pan, input logic [10:0] beam,
                             input logic [15:0] rng, input logic [15:0] inten,
                             input int gap);
    if (gap != 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.pan_angle <= pan;
    in_ch.beam_index <= beam;
    in_ch.range_mm <= rng;
    in_ch.return_intensity <= inten;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic random_gap(output int gap);
    gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 18) : 0;
  endtask

  task automatic random_return(input int gap);
    logic [15:0] pan, inten, rng;
    logic [10:0] beam;
    int sel;
    sel = $urandom_range(0, 9);
    pan = (sel == 0) ? 16'($urandom) : 16'($signed($urandom_range(0, 36000)) - 18000);
    beam = (sel == 1) ? 11'($urandom) : 11'($urandom_range(390, 690));
    rng = (sel == 2) ? 16'($urandom) : 16'($urandom_range(0, 9000));
    inten = (sel == 3) ? 16'($urandom) : 16'($urandom_range(0, 5000));
    send_return(pan, beam, rng, inten, gap);
  endtask

  task automatic run_random(input int count, input int idle_pct);
    int gap;
    for (int i = 0; i < count; i++) begin
      random_gap(gap);
      if ($urandom_range(0, 99) >= idle_pct) gap = 0;
      random_return(gap);
    end
    in_ch.valid <= 0;
  endtask

  initial begin
    logic signed [17:0] a, b;
    in_ch.valid = 0;
    in_ch.pan_angle = 0;
    in_ch.beam_index = 0;
    in_ch.range_mm = 0;
    in_ch.return_intensity = 0;
    cfg.valid = 0;
    cfg.index = lpp_pkg::REG_INT_MIN;
    cfg.data = 0;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // defaults: extremes of fields and tilt window edges
    send_return(16'sd0, 11'd400, 16'd3000, 16'd100, 0);
    send_return(16'sd0, 11'd399, 16'd3000, 16'd500, 0);
    send_return(16'sd0, 11'd680, 16'd3000, 16'd4000, 0);
    send_return(16'sd0, 11'd681, 16'd3000, 16'd500, 0);
    send_return(16'sd0, 11'd2047, 16'd3000, 16'd500, 0);
    send_return(16'sd0, 11'd540, 16'd0, 16'd500, 0);
    send_return(16'sd0, 11'd540, 16'd65535, 16'd500, 0);
    send_return(16'sd18000, 11'd540, 16'd2000, 16'd500, 0);
    send_return(-16'sd18000, 11'd540, 16'd2000, 16'd500, 0);
    send_return(16'sh7fff, 11'd540, 16'd2000, 16'd500, 0);
    send_return(16'sh8000, 11'd540, 16'd2000, 16'd500, 0);
    send_return(16'sd9000, 11'd500, 16'd2000, 16'd500, 0);
    send_return(-16'sd9000, 11'd600, 16'd2000, 16'd99, 0);
    send_return(16'sd0, 11'd540, 16'd2000, 16'd4001, 0);
    send_return(16'sd0, 11'd0, 16'd2000, 16'd0, 0);
    send_return(16'sd0, 11'd1080, 16'd2000, 16'hffff, 0);
    in_ch.valid <= 0;
    drain();

    // wide open box: saturation extremes
    write_reg(lpp_pkg::REG_INT_MIN, 18'd0);
    write_reg(lpp_pkg::REG_INT_MAX, 18'hffff);
    write_reg(lpp_pkg::REG_X_MIN, 18'sh20000);
    write_reg(lpp_pkg::REG_X_MAX, 18'sh1ffff);
    write_reg(lpp_pkg::REG_Y_MIN, 18'sh20000);
    write_reg(lpp_pkg::REG_Y_MAX, 18'sh1ffff);
    write_reg(lpp_pkg::REG_Z_MIN, 18'sh20000);
    write_reg(lpp_pkg::REG_Z_MAX, 18'sh1ffff);
    write_reg(lpp_pkg::reg_idx_t'(4'd9), 18'd5);
    send_return(16'sd0, 11'd680, 16'd65535, 16'd0, 0);
    send_return(16'sd18000, 11'd400, 16'd65535, 16'hffff, 0);
    send_return(16'sd9000, 11'd540, 16'd65535, 16'd7, 0);
    send_return(-16'sd9000, 11'd540, 16'd65535, 16'd7, 0);
    in_ch.valid <= 0;
    drain();

    // long receiver hold-off while input keeps coming
    sink_hold <= 1;
    fork
      begin
        repeat (300) @(posedge clk);
        sink_hold <= 0;
      end
      run_random(150, 0);
    join
    drain();
    run_random(500, 40);
    drain();

    // inverted bounds reject everything
    write_reg(lpp_pkg::REG_X_MIN, 18'sd100);
    write_reg(lpp_pkg::REG_X_MAX, 18'sd50);
    run_random(60, 30);
    drain();

    // random register sets
    for (int ph = 0; ph < 6; ph++) begin
      a = 18'($signed($urandom_range(0, 8000)) - 8000);
      b = 18'($urandom_range(0, 12000));
      write_reg(lpp_pkg::REG_X_MIN, a);
      write_reg(lpp_pkg::REG_X_MAX, b);
      write_reg(lpp_pkg::REG_Y_MIN, 18'($signed($urandom_range(0, 10000)) - 10000));
      write_reg(lpp_pkg::REG_Y_MAX, 18'($urandom_range(0, 10000)));
      write_reg(lpp_pkg::REG_Z_MIN, 18'($signed($urandom_range(0, 6000)) - 6000));
      write_reg(lpp_pkg::REG_Z_MAX, 18'($urandom_range(0, 9000)));
      write_reg(lpp_pkg::REG_INT_MIN, 18'($urandom_range(0, 1000)));
      write_reg(lpp_pkg::REG_INT_MAX, 18'($urandom_range(1000, 65535)));
      run_random(120, 50);
      drain();
    end

    @(posedge clk);
    if (fail_count == 0 && pending_points == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/lpp_pkg.sv
src/lpp_ifs.sv
src/lpp_cordic.sv
src/lidar_point_project_filter_top.sv
sim/lpp_checker.sv
sim/testbench.sv
